>>> rtl/pste_pkg.sv
// Shared types and constants for the piecewise trajectory evaluator.
// Holds request codes, datapath command/status structs and the controller state type.
// No dependencies.
package pste_pkg;

    localparam int unsigned AXES   = 3;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned SUM_W  = 48;
    localparam int unsigned DVD_W  = 64;

    // Normalised time of exactly one: one integer bit over 32 fraction bits
    localparam logic [32:0] U_ONE = 33'h1_0000_0000;

    localparam logic [1:0] REQ_KNOT = 2'd0;
    localparam logic [1:0] REQ_COEF = 2'd1;
    localparam logic [1:0] REQ_EVAL = 2'd2;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [1:0] AXIS_BAD  = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RD_END,
        OP_CLAMP,
        OP_SCAN,
        OP_SEG_S,
        OP_SEG_E,
        OP_SEG_F,
        OP_U_SET,
        OP_POW,
        OP_TERM_RD,
        OP_MUL,
        OP_ACC,
        OP_AX_CLR,
        OP_POS_SAVE,
        OP_DIV_START,
        OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        DIV_U,
        DIV_V,
        DIV_A1,
        DIV_A2
    } div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_END,
        S_CLAMP,
        S_SCAN,
        S_SEG_S,
        S_SEG_E,
        S_SEG_F,
        S_U_SET,
        S_DIV_GO,
        S_DIV_WAIT,
        S_POW,
        S_AX_CLR,
        S_TERM_RD,
        S_MUL,
        S_ACC,
        S_FIN,
        S_A_CHK,
        S_NEXT_AX,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        div_sel_t   div_sel;
        logic       accept;
        logic [1:0] sub;
        logic [1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic need_udiv;
        logic fault;
        logic a1_sat;
        logic div_done;
        logic out_free;
    } dp_status_t;

    function automatic logic [31:0] sat32(input logic signed [65:0] x);
        logic [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (x < -66'sd2147483648)
            r = 32'h8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

>>> rtl/pste_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module pste_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/pste_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Depends on pste_pkg.
module pste_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pste_pkg::DVD_W-1:0]  dividend,
    input  logic [pste_pkg::WORD_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [pste_pkg::DVD_W-1:0]  quotient
);
    import pste_pkg::*;

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  q_reg;
    logic [WORD_W:0]   rem_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg[WORD_W-1:0], q_reg[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Shift the dividend out as the quotient shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/pste_ctrl.sv
// Sequencing state machine: knot scan, normalised time, powers, terms and divisions.
// Depends on pste_pkg; drives pste_dp through command and status structs.
module pste_ctrl #(
    parameter int unsigned POLY_TERMS = 8,
    parameter int unsigned CW = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [1:0]              req_type,
    output logic                    in_stall,
    input  pste_pkg::dp_status_t    st,
    output pste_pkg::dp_cmd_t       cmd,
    output logic [CW-1:0]           cnt
);
    import pste_pkg::*;

    ctrl_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    sub_reg, sub_next;
    logic [1:0]    axis_reg, axis_next;
    div_sel_t      sel_reg, sel_next;
    logic          k_last;

    assign k_last = (cnt_reg == CW'(POLY_TERMS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        axis_next  = axis_reg;
        sel_next   = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (req_type == REQ_EVAL))
                    state_next = S_RD_END;
            end
            S_RD_END:
                state_next = S_CLAMP;
            S_CLAMP:
            begin
                cnt_next   = '0;
                axis_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (st.scan_last)
                    state_next = S_SEG_S;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_SEG_S:
                state_next = S_SEG_E;
            S_SEG_E:
                state_next = S_SEG_F;
            S_SEG_F:
                state_next = S_U_SET;
            S_U_SET:
            begin
                if (st.need_udiv)
                begin
                    sel_next   = DIV_U;
                    state_next = S_DIV_GO;
                end
                else
                begin
                    cnt_next   = CW'(1);
                    state_next = S_POW;
                end
            end
            S_DIV_GO:
                state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    case (sel_reg)
                        DIV_U:
                        begin
                            cnt_next   = CW'(1);
                            state_next = S_POW;
                        end
                        DIV_V:
                        begin
                            sel_next   = DIV_A1;
                            state_next = S_DIV_GO;
                        end
                        DIV_A1:
                            state_next = S_A_CHK;
                        default:
                            state_next = S_NEXT_AX;
                    endcase
                end
            end
            S_POW:
            begin
                if (k_last)
                    state_next = S_AX_CLR;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_AX_CLR:
            begin
                cnt_next   = '0;
                state_next = S_TERM_RD;
            end
            S_TERM_RD:
            begin
                sub_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
                state_next = S_ACC;
            S_ACC:
            begin
                if ((sub_reg != 2'd2) && (CW'(sub_reg) < cnt_reg))
                begin
                    sub_next   = sub_reg + 2'd1;
                    state_next = S_MUL;
                end
                else if (k_last)
                    state_next = S_FIN;
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_TERM_RD;
                end
            end
            S_FIN:
            begin
                if (st.fault)
                    state_next = S_NEXT_AX;
                else
                begin
                    sel_next   = DIV_V;
                    state_next = S_DIV_GO;
                end
            end
            S_A_CHK:
            begin
                if (st.a1_sat)
                    state_next = S_NEXT_AX;
                else
                begin
                    sel_next   = DIV_A2;
                    state_next = S_DIV_GO;
                end
            end
            S_NEXT_AX:
            begin
                if (axis_reg == AXIS_LAST)
                    state_next = S_OUT;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_AX_CLR;
                end
            end
            S_OUT:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.div_sel = sel_reg;
        cmd.accept  = 1'b0;
        cmd.sub     = sub_reg;
        cmd.axis    = axis_reg;
        case (state_reg)
            S_IDLE:     cmd.accept = in_valid;
            S_RD_END:   cmd.op = OP_RD_END;
            S_CLAMP:    cmd.op = OP_CLAMP;
            S_SCAN:     cmd.op = OP_SCAN;
            S_SEG_S:    cmd.op = OP_SEG_S;
            S_SEG_E:    cmd.op = OP_SEG_E;
            S_SEG_F:    cmd.op = OP_SEG_F;
            S_U_SET:    cmd.op = OP_U_SET;
            S_DIV_GO:   cmd.op = OP_DIV_START;
            S_POW:      cmd.op = OP_POW;
            S_AX_CLR:   cmd.op = OP_AX_CLR;
            S_TERM_RD:  cmd.op = OP_TERM_RD;
            S_MUL:      cmd.op = OP_MUL;
            S_ACC:      cmd.op = OP_ACC;
            S_FIN:      cmd.op = OP_POS_SAVE;
            S_OUT:      cmd.op = st.out_free ? OP_OUT : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
    assign cnt      = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sub_reg   <= '0;
            axis_reg  <= '0;
            sel_reg   <= DIV_U;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            axis_reg  <= axis_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

>>> rtl/pste_dp.sv
// Datapath: knot and coefficient RAMs, power and term multipliers, sums, divider, result registers.
// Depends on pste_pkg, pste_ram and pste_div; commanded by pste_ctrl.
module pste_dp #(
    parameter int unsigned MAX_SEGMENTS = 16,
    parameter int unsigned POLY_TERMS = 8,
    parameter int unsigned CW = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pste_pkg::dp_cmd_t    cmd,
    input  logic [CW-1:0]        cnt,
    output pste_pkg::dp_status_t st,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata,
    input  logic [1:0]           req_type,
    input  logic [4:0]           entry_index,
    input  logic [1:0]           axis_select,
    input  logic [2:0]           power_index,
    input  logic signed [31:0]   write_value,
    input  logic [31:0]          sample_time,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   pos_z,
    output logic signed [31:0]   vel_x,
    output logic signed [31:0]   vel_y,
    output logic signed [31:0]   vel_z,
    output logic signed [31:0]   acc_x,
    output logic signed [31:0]   acc_y,
    output logic signed [31:0]   acc_z,
    output logic [3:0]           segment_used,
    output logic                 fault
);
    import pste_pkg::*;

    localparam int unsigned KW     = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned CDEPTH = MAX_SEGMENTS * AXES * POLY_TERMS;
    localparam int unsigned CAW    = $clog2(CDEPTH);
    localparam int unsigned PIW    = $clog2(POLY_TERMS);

    // Configuration and request decode
    logic [4:0]        seg_count_reg;
    logic [KW-1:0]     n_eff;
    logic              knot_we, coef_we;
    logic [KW-1:0]     knot_raddr;
    logic [31:0]       coef_waddr_full, coef_raddr_full;
    logic [WORD_W-1:0] knot_rdata, coef_rdata;

    // Evaluation state
    logic [31:0]        t_reg, s_reg, tlen_reg, d_reg;
    logic [KW-1:0]      n_reg, idx_reg;
    logic               stop_reg, fault_reg, a1_sat_reg;
    logic [32:0]        u_reg;
    logic [32:0]        pw_reg [POLY_TERMS];
    logic [PIW-1:0]     pw_ridx;
    logic [32:0]        pw_rd, pw_new;
    logic [63:0]        pw_prod;
    logic signed [63:0] prod_reg;
    logic signed [64:0] prod_full;
    logic signed [31:0] term;
    logic [5:0]         kk, weight;
    logic signed [38:0] wterm;
    logic signed [SUM_W-1:0] sp_reg, sv_reg, sa_reg;
    logic [SUM_W-1:0]   sv_mag, sa_mag;
    logic [63:0]        q1_mag_reg;
    logic               q1_neg_reg;

    // Divider
    logic [DVD_W-1:0]   div_dvd, div_q;
    logic               div_neg, div_neg_reg;
    logic               div_busy, div_done;
    logic signed [65:0] qs;

    // Per-axis results and the output register
    logic [31:0] res_pos [AXES];
    logic [31:0] res_vel [AXES];
    logic [31:0] res_acc [AXES];
    logic [31:0] o_pos [AXES];
    logic [31:0] o_vel [AXES];
    logic [31:0] o_acc [AXES];
    logic [3:0]  o_seg_reg;
    logic        o_fault_reg;
    logic        out_valid_reg;
    logic        out_free;

    always_comb
    begin
        if (seg_count_reg == 5'd0)
            n_eff = KW'(1);
        else if ({27'b0, seg_count_reg} > 32'(MAX_SEGMENTS))
            n_eff = KW'(MAX_SEGMENTS);
        else
            n_eff = KW'(seg_count_reg);
    end

    assign knot_we = cmd.accept && (req_type == REQ_KNOT)
                     && ({27'b0, entry_index} <= 32'(MAX_SEGMENTS));
    assign coef_we = cmd.accept && (req_type == REQ_COEF)
                     && ({27'b0, entry_index} < 32'(MAX_SEGMENTS))
                     && (axis_select != AXIS_BAD)
                     && ({29'b0, power_index} < 32'(POLY_TERMS));

    assign coef_waddr_full = (32'(entry_index) * 32'(AXES) + 32'(axis_select))
                             * 32'(POLY_TERMS) + 32'(power_index);
    assign coef_raddr_full = (32'(idx_reg) * 32'(AXES) + 32'(cmd.axis))
                             * 32'(POLY_TERMS) + 32'(cnt);

    always_comb
    begin
        case (cmd.op)
            OP_RD_END: knot_raddr = n_reg;
            OP_SCAN:   knot_raddr = KW'(cnt) + KW'(1);
            OP_SEG_S:  knot_raddr = idx_reg;
            OP_SEG_E:  knot_raddr = idx_reg + KW'(1);
            default:   knot_raddr = '0;
        endcase
    end

    pste_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SEGMENTS + 1)
    ) u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (KW'(entry_index)),
        .wdata (write_value),
        .raddr (knot_raddr),
        .rdata (knot_rdata)
    );

    pste_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (CAW'(coef_waddr_full)),
        .wdata (write_value),
        .raddr (CAW'(coef_raddr_full)),
        .rdata (coef_rdata)
    );

    // Power and term arithmetic
    assign pw_ridx = (cmd.op == OP_POW) ? PIW'(cnt - CW'(1)) : PIW'(cnt - CW'(cmd.sub));
    assign pw_rd   = pw_reg[pw_ridx];
    assign pw_prod = 64'(pw_rd[31:0]) * 64'(u_reg[31:0]);

    always_comb
    begin
        if (pw_rd[32])
            pw_new = u_reg;
        else if (u_reg[32])
            pw_new = pw_rd;
        else
            pw_new = {1'b0, pw_prod[63:32]};
    end

    assign prod_full = 65'($signed(coef_rdata)) * 65'($signed({1'b0, pw_rd[31:0]}));
    assign term      = prod_reg[63:32];
    assign kk        = 6'(cnt);

    always_comb
    begin
        case (cmd.sub)
            2'd0:    weight = 6'd1;
            2'd1:    weight = kk;
            default: weight = 6'(kk * (kk - 6'd1));
        endcase
    end

    assign wterm = 39'(term) * 39'($signed({1'b0, weight}));

    // Divider operand selection
    assign sv_mag = sv_reg[SUM_W-1] ? SUM_W'(-sv_reg) : SUM_W'(sv_reg);
    assign sa_mag = sa_reg[SUM_W-1] ? SUM_W'(-sa_reg) : SUM_W'(sa_reg);

    always_comb
    begin
        case (cmd.div_sel)
            DIV_U:
            begin
                div_dvd = {d_reg, 32'h0};
                div_neg = 1'b0;
            end
            DIV_V:
            begin
                div_dvd = DVD_W'({sv_mag, 16'h0});
                div_neg = sv_reg[SUM_W-1];
            end
            DIV_A1:
            begin
                div_dvd = DVD_W'({sa_mag, 16'h0});
                div_neg = sa_reg[SUM_W-1];
            end
            default:
            begin
                div_dvd = {q1_mag_reg[47:0], 16'h0};
                div_neg = q1_neg_reg;
            end
        endcase
    end

    pste_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_START),
        .dividend (div_dvd),
        .divisor  (tlen_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign qs = div_neg_reg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

    // Control state
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= 5'd1;
            out_valid_reg <= 1'b0;
            u_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
                seg_count_reg <= cfg_wdata;
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if ((cmd.op == OP_U_SET) && !st.need_udiv)
                u_reg <= fault_reg ? 33'h0 : U_ONE;
            else if (div_done && (cmd.div_sel == DIV_U))
                u_reg <= {1'b0, div_q[31:0]};
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (req_type == REQ_EVAL))
        begin
            t_reg     <= sample_time;
            n_reg     <= n_eff;
            pw_reg[0] <= U_ONE;
        end
        case (cmd.op)
            OP_CLAMP:
            begin
                if (t_reg >= knot_rdata)
                    t_reg <= knot_rdata;
                idx_reg  <= '0;
                stop_reg <= 1'b0;
            end
            OP_SCAN:
            begin
                if (!stop_reg)
                begin
                    if (t_reg < knot_rdata)
                        stop_reg <= 1'b1;
                    else
                        idx_reg <= KW'(cnt);
                end
            end
            OP_SEG_E:
                s_reg <= knot_rdata;
            OP_SEG_F:
            begin
                fault_reg <= (knot_rdata <= s_reg);
                tlen_reg  <= knot_rdata - s_reg;
                d_reg     <= (t_reg > s_reg) ? (t_reg - s_reg) : 32'h0;
            end
            OP_POW:
                pw_reg[PIW'(cnt)] <= pw_new;
            OP_AX_CLR:
            begin
                sp_reg <= '0;
                sv_reg <= '0;
                sa_reg <= '0;
            end
            OP_MUL:
                prod_reg <= pw_rd[32] ? {coef_rdata, 32'h0} : prod_full[63:0];
            OP_ACC:
            begin
                case (cmd.sub)
                    2'd0:    sp_reg <= sp_reg + SUM_W'(wterm);
                    2'd1:    sv_reg <= sv_reg + SUM_W'(wterm);
                    default: sa_reg <= sa_reg + SUM_W'(wterm);
                endcase
            end
            OP_POS_SAVE:
            begin
                res_pos[cmd.axis] <= sat32(66'(sp_reg));
                if (fault_reg)
                begin
                    res_vel[cmd.axis] <= '0;
                    res_acc[cmd.axis] <= '0;
                end
            end
            OP_DIV_START:
                div_neg_reg <= div_neg;
            OP_OUT:
            begin
                o_pos       <= res_pos;
                o_vel       <= res_vel;
                o_acc       <= res_acc;
                o_seg_reg   <= 4'(idx_reg);
                o_fault_reg <= fault_reg;
            end
            default:
            begin
            end
        endcase
        if (div_done)
        begin
            case (cmd.div_sel)
                DIV_V:
                    res_vel[cmd.axis] <= sat32(qs);
                DIV_A1:
                begin
                    q1_mag_reg <= div_q;
                    q1_neg_reg <= div_neg_reg;
                    a1_sat_reg <= (div_q[63:47] != '0);
                    res_acc[cmd.axis] <= div_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                DIV_A2:
                    res_acc[cmd.axis] <= sat32(qs);
                default:
                begin
                end
            endcase
        end
    end

    assign st.scan_last = (KW'(cnt) == (n_reg - KW'(1)));
    assign st.need_udiv = !fault_reg && (d_reg < tlen_reg);
    assign st.fault     = fault_reg;
    assign st.a1_sat    = a1_sat_reg;
    assign st.div_done  = div_done;
    assign st.out_free  = out_free;

    assign out_valid    = out_valid_reg;
    assign pos_x        = o_pos[0];
    assign pos_y        = o_pos[1];
    assign pos_z        = o_pos[2];
    assign vel_x        = o_vel[0];
    assign vel_y        = o_vel[1];
    assign vel_z        = o_vel[2];
    assign acc_x        = o_acc[0];
    assign acc_y        = o_acc[1];
    assign acc_z        = o_acc[2];
    assign segment_used = o_seg_reg;
    assign fault        = o_fault_reg;

    a_u_bound: assert property (@(posedge clk) disable iff (!rst_n)
        u_reg[32] |-> (u_reg[31:0] == 32'h0))
        else $error("normalised time above one");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DIV_START) |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> $past(div_busy))
        else $error("divider finished without running");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_fault_reg) |-> ((o_vel[0] == 32'h0) && (o_acc[0] == 32'h0)))
        else $error("fault result carries motion");

endmodule

>>> rtl/piecewise_septic_trajectory_eval_top.sv
// Piecewise seventh-order trajectory evaluator. One item is in work at a time; a finished
// result waits in the output register. rst_n clears control and sets segment_count to 1;
// table contents stay undefined until written.
module piecewise_septic_trajectory_eval_top #(
    parameter int unsigned MAX_SEGMENTS = 16,
    parameter int unsigned POLY_TERMS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [4:0]         entry_index,
    input  logic [1:0]         axis_select,
    input  logic [2:0]         power_index,
    input  logic signed [31:0] write_value,
    input  logic [31:0]        sample_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic signed [31:0] acc_x,
    output logic signed [31:0] acc_y,
    output logic signed [31:0] acc_z,
    output logic [3:0]         segment_used,
    output logic               fault
);
    import pste_pkg::*;

    // Counter must index both the knot scan and the polynomial terms
    localparam int unsigned CW =
        $clog2(((MAX_SEGMENTS > POLY_TERMS) ? MAX_SEGMENTS : POLY_TERMS) + 1);

    dp_cmd_t    cmd;
    dp_status_t st;
    logic [CW-1:0] cnt;

    // Controller: walks the knot scan, the division for normalised time, then the power chain,
    // then per axis the term products and the velocity and acceleration divisions.
    pste_ctrl #(
        .POLY_TERMS (POLY_TERMS),
        .CW         (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd),
        .cnt      (cnt)
    );

    // Datapath: tables, arithmetic and the output register that holds a
    // finished transfer while the next request is taken.
    pste_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .POLY_TERMS   (POLY_TERMS),
        .CW           (CW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cnt          (cnt),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .axis_select  (axis_select),
        .power_index  (power_index),
        .write_value  (write_value),
        .sample_time  (sample_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .acc_x        (acc_x),
        .acc_y        (acc_y),
        .acc_z        (acc_z),
        .segment_used (segment_used),
        .fault        (fault)
    );

endmodule

>>> tb/piecewise_septic_trajectory_eval_top_tb.sv
// Self-checking testbench for piecewise_septic_trajectory_eval_top.
// Depends on pste_pkg (request and axis codes) and the evaluator RTL; carries its own trajectory predictor.
// Drives knot and coefficient loads and evaluations through several segment counts, with random gaps.
module piecewise_septic_trajectory_eval_top_tb;
    import pste_pkg::*;

    localparam int unsigned SEGS      = 16;
    localparam int unsigned TERMS     = 8;
    localparam int unsigned WATCHDOG  = 40000;
    localparam int unsigned HOLD_LONG = 3000;
    localparam int unsigned ITEMS_PER_PHASE = 70;

    typedef struct packed {
        logic [1:0]  req;
        logic [4:0]  entry;
        logic [1:0]  axis;
        logic [2:0]  power;
        logic [31:0] wval;
        logic [31:0] t;
    } traj_req_t;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] acc;
        logic [3:0]       seg;
        logic             flt;
    } traj_sample_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [4:0]         cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         req_type;
    logic [4:0]         entry_index;
    logic [1:0]         axis_select;
    logic [2:0]         power_index;
    logic signed [31:0] write_value;
    logic [31:0]        sample_time;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic signed [31:0] acc_x, acc_y, acc_z;
    logic [3:0]         segment_used;
    logic               fault;

    piecewise_septic_trajectory_eval_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .entry_index(entry_index), .axis_select(axis_select),
        .power_index(power_index), .write_value(write_value), .sample_time(sample_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .segment_used(segment_used), .fault(fault)
    );

    // Predictor state: what the block's tables and register hold after each transfer
    logic [31:0] knot_mem [0:SEGS];
    logic [31:0] coef_mem [0:SEGS*AXES*TERMS-1];
    logic [4:0]  seg_cfg;

    // Generator shadow: which entries have been loaded, and the knot values queued so far
    bit          knot_ok  [0:SEGS];
    bit          coef_ok  [0:SEGS*AXES*TERMS-1];
    logic [31:0] gen_knot [0:SEGS];
    logic [4:0]  gen_cfg;

    traj_req_t    pending_reqs[$];
    traj_sample_t expected_samples[$];

    int unsigned errors;
    int unsigned evals_checked;
    int unsigned faults_seen;
    int unsigned idle_cycles;
    bit          took;
    int unsigned send_gap;
    bit          send_calm;
    int unsigned stall_left;
    bit          recv_calm;
    bit          hold_go;
    bit          hold_started;
    int unsigned hold_count;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int unsigned eff_count(logic [4:0] v);
        if (v == 0)
            return 1;
        if (v > SEGS)
            return SEGS;
        return v;
    endfunction

    function automatic logic [31:0] clip32(logic signed [127:0] x);
        if (x > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (x < -128'sd2147483648)
            return 32'h8000_0000;
        return x[31:0];
    endfunction

    // floor(c * p / 2^32), with p a fraction holding 32 fraction bits
    function automatic logic signed [127:0] frac_term(logic [31:0] c, logic [63:0] p);
        logic signed [127:0] cs;
        logic signed [127:0] ps;
        cs = $signed(c);
        ps = $signed({64'd0, p});
        return (cs * ps) >>> 32;
    endfunction

    function automatic traj_sample_t predict_sample(logic [31:0] t_in);
        int unsigned n;
        int unsigned idx;
        int unsigned base;
        logic [31:0] t;
        logic [31:0] s;
        logic [31:0] e;
        logic [63:0] u;
        logic [63:0] tlen;
        logic [63:0] d;
        logic [63:0] pw [0:TERMS-1];
        logic signed [127:0] sp, sv, sa, q1, tl;
        logic [31:0] vel, acc;
        bit flt;
        traj_sample_t r;
        n = eff_count(seg_cfg);
        t = t_in;
        if (t >= knot_mem[n])
            t = knot_mem[n];
        idx = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (t < knot_mem[i])
                break;
            idx = i;
        end
        s = knot_mem[idx];
        e = knot_mem[idx + 1];
        flt = (e <= s);
        u = 0;
        tlen = 0;
        if (!flt)
        begin
            tlen = {32'd0, e} - {32'd0, s};
            d = (t > s) ? ({32'd0, t} - {32'd0, s}) : 64'd0;
            u = (d >= tlen) ? 64'h1_0000_0000 : ((d << 32) / tlen);
        end
        pw[0] = 64'h1_0000_0000;
        for (int unsigned k = 1; k < TERMS; k++)
        begin
            if (pw[k-1] == 64'h1_0000_0000)
                pw[k] = u;
            else if (u == 64'h1_0000_0000)
                pw[k] = pw[k-1];
            else
                pw[k] = (pw[k-1] * u) >> 32;
        end
        tl = $signed({64'd0, tlen});
        for (int unsigned a = 0; a < AXES; a++)
        begin
            base = (idx * AXES + a) * TERMS;
            sp = 0;
            sv = 0;
            sa = 0;
            vel = 0;
            acc = 0;
            for (int unsigned k = 0; k < TERMS; k++)
            begin
                sp += frac_term(coef_mem[base + k], pw[k]);
                if (k >= 1)
                    sv += $signed(128'(k)) * frac_term(coef_mem[base + k], pw[k-1]);
                if (k >= 2)
                    sa += $signed(128'(k * (k - 1))) * frac_term(coef_mem[base + k], pw[k-2]);
            end
            if (!flt)
            begin
                vel = clip32((sv * 65536) / tl);
                q1 = (sa * 65536) / tl;
                if (q1 >= (128'sd1 <<< 47))
                    acc = 32'h7FFF_FFFF;
                else if (q1 <= -(128'sd1 <<< 47))
                    acc = 32'h8000_0000;
                else
                    acc = clip32((q1 * 65536) / tl);
            end
            r.pos[a] = clip32(sp);
            r.vel[a] = vel;
            r.acc[a] = acc;
        end
        r.seg = idx[3:0];
        r.flt = flt;
        return r;
    endfunction

    // Apply one accepted request to the predictor; queue a sample where one is due
    function automatic void apply_request(traj_req_t it);
        if (it.req == REQ_KNOT)
        begin
            if (it.entry <= SEGS)
                knot_mem[it.entry] = it.wval;
        end
        else if (it.req == REQ_COEF)
        begin
            if (it.entry < SEGS && it.axis <= AXIS_LAST)
                coef_mem[(it.entry * AXES + it.axis) * TERMS + it.power] = it.wval;
        end
        else if (it.req == REQ_EVAL)
            expected_samples.push_back(predict_sample(it.t));
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic int unsigned coef_slot(int unsigned sg, int unsigned ax, int unsigned pw);
        return (sg * AXES + ax) * TERMS + pw;
    endfunction

    // Queue a request and track what it loads
    task automatic queue_req(traj_req_t it);
        if (it.req == REQ_KNOT && it.entry <= SEGS)
        begin
            knot_ok[it.entry] = 1;
            gen_knot[it.entry] = it.wval;
        end
        if (it.req == REQ_COEF && it.entry < SEGS && it.axis <= AXIS_LAST)
            coef_ok[coef_slot(it.entry, it.axis, it.power)] = 1;
        pending_reqs.push_back(it);
    endtask

    function automatic traj_req_t make_req(logic [1:0] rq, logic [4:0] ent, logic [1:0] ax,
                                           logic [2:0] pw, logic [31:0] wv, logic [31:0] tv);
        traj_req_t it;
        it.req = rq;
        it.entry = ent;
        it.axis = ax;
        it.power = pw;
        it.wval = wv;
        it.t = tv;
        return it;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // Step from one knot to the next; mostly a sensible length, sometimes empty or tiny
    function automatic logic [31:0] rand_step();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return $urandom_range(1, 4);
            2: return $urandom_range(5, 32'h0000_1000);
            default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
        endcase
    endfunction

    function automatic traj_req_t next_fill();
        int unsigned n;
        n = eff_count(gen_cfg);
        for (int unsigned i = 0; i <= n; i++)
            if (!knot_ok[i])
                return make_req(REQ_KNOT, i[4:0], $urandom_range(0, 3), $urandom(),
                                (i == 0) ? $urandom_range(0, 32'h0004_0000)
                                         : gen_knot[i-1] + rand_step(), $urandom());
        for (int unsigned sl = 0; sl < n * AXES * TERMS; sl++)
            if (!coef_ok[sl])
                return make_req(REQ_COEF, 5'(sl / (AXES * TERMS)), 2'((sl / TERMS) % AXES),
                                3'(sl % TERMS), rand_coef(), $urandom());
        return make_req(REQ_EVAL, 0, 0, 0, 0, 0);
    endfunction

    function automatic logic [31:0] rand_sample_time();
        int unsigned n;
        logic [63:0] span;
        n = eff_count(gen_cfg);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return gen_knot[$urandom_range(0, n)];
            2: return gen_knot[0] - $urandom_range(0, 32'h0001_0000);
            3: return gen_knot[n] + $urandom_range(0, 32'h0001_0000);
            default:
            begin
                span = (gen_knot[n] >= gen_knot[0]) ? {32'd0, gen_knot[n] - gen_knot[0]} : 64'd0;
                return gen_knot[0] + 32'({$urandom(), $urandom()} % (span + 1));
            end
        endcase
    endfunction

    // One random item; the return tells whether it does something in the block
    task automatic queue_random(output bit counted);
        traj_req_t it;
        int unsigned i;
        it = next_fill();
        counted = 1;
        if (it.req != REQ_EVAL)
        begin
            queue_req(it);
            return;
        end
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                i = $urandom_range(0, SEGS);
                it = make_req(REQ_KNOT, i[4:0], $urandom_range(0, 3), $urandom(),
                              ($urandom_range(0, 4) == 0 || i == 0) ? $urandom()
                                  : gen_knot[i-1] + rand_step(), $urandom());
            end
            3, 4, 5:
                it = make_req(REQ_COEF, $urandom_range(0, SEGS - 1), $urandom_range(0, 2),
                              $urandom(), rand_coef(), $urandom());
            6:
            begin
                // address out of range, or an unused request code: ignored by the block
                counted = 0;
                case ($urandom_range(0, 2))
                    0: it = make_req(REQ_KNOT, $urandom_range(SEGS + 1, 31), $urandom(),
                                     $urandom(), $urandom(), $urandom());
                    1: it = make_req(REQ_COEF, $urandom_range(0, 31), AXIS_BAD,
                                     $urandom(), $urandom(), $urandom());
                    default: it = make_req(2'd3, $urandom(), $urandom(), $urandom(),
                                           $urandom(), $urandom());
                endcase
            end
            default:
                it = make_req(REQ_EVAL, $urandom(), $urandom(), $urandom(), $urandom(),
                              rand_sample_time());
        endcase
        queue_req(it);
    endtask

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && !in_valid && expected_samples.size() == 0);
        // a trailing table write may still be in the block
        repeat (40) @(posedge clk);
    endtask

    task automatic write_count(logic [4:0] v);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        gen_cfg = v;
    endtask

    task automatic run_phase(int unsigned quota, bit pause_mid);
        int unsigned done;
        bit counted;
        done = 0;
        while (done < quota)
        begin
            queue_random(counted);
            if (counted)
                done++;
            if (pause_mid && done == quota / 2)
            begin
                // hold back the sender until every sample is home
                wait (pending_reqs.size() == 0 && !in_valid && expected_samples.size() == 0);
                pause_mid = 0;
            end
            // keep the queue short so the pending list tracks the generator closely
            wait (pending_reqs.size() < 8);
        end
    endtask

    // Directed opening: extremes, every request code, each corner of the evaluation
    task automatic queue_directed();
        queue_req(make_req(REQ_KNOT, 0, 0, 0, 32'h0001_0000, 0));
        queue_req(make_req(REQ_KNOT, 1, 0, 0, 32'h0003_0000, 0));
        for (int unsigned ax = 0; ax < AXES; ax++)
            for (int unsigned k = 0; k < TERMS; k++)
                queue_req(make_req(REQ_COEF, 0, ax[1:0], k[2:0],
                                   (ax == 0) ? 32'h7FFF_FFFF : (ax == 1) ? 32'h8000_0000
                                             : 32'(k) * 32'h0001_0000 - 32'h0003_0000, 0));
        queue_req(make_req(REQ_EVAL, 0, 0, 0, 0, 32'h0000_0000));
        queue_req(make_req(REQ_EVAL, 0, 0, 0, 0, 32'h0001_0000));
        queue_req(make_req(REQ_EVAL, 0, 0, 0, 0, 32'h0002_0000));
        queue_req(make_req(REQ_EVAL, 31, 3, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_req(make_req(REQ_KNOT, 1, 0, 0, 32'h0001_0001, 0));
        queue_req(make_req(REQ_EVAL, 0, 0, 0, 0, 32'h0001_0001));
        queue_req(make_req(REQ_KNOT, 1, 0, 0, 32'h0001_0000, 0));
        queue_req(make_req(REQ_EVAL, 0, 0, 0, 0, 32'h0001_0000));
        queue_req(make_req(REQ_KNOT, 1, 0, 0, 32'h0000_8000, 0));
        queue_req(make_req(REQ_EVAL, 0, 0, 0, 0, 32'h0000_C000));
        queue_req(make_req(REQ_KNOT, 17, 0, 0, 32'h1234_5678, 0));
        queue_req(make_req(REQ_COEF, 16, 0, 0, 32'h1234_5678, 0));
        queue_req(make_req(REQ_COEF, 0, AXIS_BAD, 0, 32'h1234_5678, 0));
        queue_req(make_req(2'd3, 0, 0, 0, 32'h1234_5678, 32'h0001_8000));
        queue_req(make_req(REQ_KNOT, 1, 0, 0, 32'h0003_0000, 0));
        queue_req(make_req(REQ_EVAL, 0, 0, 0, 0, 32'h0001_8000));
    endtask

    // ---------------------------------------------------------------
    // Clock, reset and the main sequence
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_go = 1'b0;
        gen_cfg = 5'd1;
        for (int i = 0; i <= SEGS; i++)
        begin
            knot_ok[i] = 0;
            gen_knot[i] = 0;
        end
        for (int i = 0; i < SEGS * AXES * TERMS; i++)
            coef_ok[i] = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        run_phase(ITEMS_PER_PHASE, 1'b0);
        write_count(5'd2);
        run_phase(ITEMS_PER_PHASE, 1'b1);
        // full table: the receiver blocks for a long stretch while the sender keeps offering
        write_count(5'd16);
        hold_go = 1'b1;
        run_phase(ITEMS_PER_PHASE, 1'b0);
        write_count(5'd0);
        run_phase(ITEMS_PER_PHASE / 2, 1'b0);
        write_count(5'd31);
        run_phase(ITEMS_PER_PHASE, 1'b0);
        write_count(5'd5);
        run_phase(ITEMS_PER_PHASE, 1'b0);

        wait (pending_reqs.size() == 0 && !in_valid && expected_samples.size() == 0);
        repeat (50) @(posedge clk);
        $display("Covered segment counts 1, 2, 16, 0, 31 and 5 with directed corners and random");
        $display("loads; %0d samples checked, %0d of them with an empty segment.",
                 evals_checked, faults_seen);
        if (errors == 0)
            $display("piecewise_septic_trajectory_eval_top test passed");
        else
            $display("piecewise_septic_trajectory_eval_top test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: present the next request on the falling edge once the
    // previous one has been transferred, with random gaps in between
    // ---------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        traj_req_t it;
        bit nxt_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= '0;
            entry_index <= '0;
            axis_select <= '0;
            power_index <= '0;
            write_value <= '0;
            sample_time <= '0;
            send_gap = 0;
            send_calm = 0;
        end
        else if (!in_valid || took)
        begin
            nxt_valid = 1'b0;
            if ($urandom_range(0, 299) == 0)
                send_calm = ~send_calm;
            if (send_gap > 0)
                send_gap--;
            else if (pending_reqs.size() > 0)
            begin
                it = pending_reqs.pop_front();
                req_type <= it.req;
                entry_index <= it.entry;
                axis_select <= it.axis;
                power_index <= it.power;
                write_value <= it.wval;
                sample_time <= it.t;
                nxt_valid = 1'b1;
                // gap to leave after this item: mostly none or short, now and then long
                if (send_calm)
                    send_gap = 0;
                else
                    case ($urandom_range(0, 9))
                        0, 1, 2: send_gap = $urandom_range(1, 3);
                        3: send_gap = $urandom_range(10, 120);
                        default: send_gap = 0;
                    endcase
            end
            in_valid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall: random short and long stalls, calm stretches,
    // and one long hold that fills the block
    // ---------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            recv_calm = 0;
            hold_started = 0;
            hold_count = 0;
        end
        else if (hold_go && !hold_started && expected_samples.size() > 0)
        begin
            hold_started = 1;
            hold_count = HOLD_LONG;
            out_stall <= 1'b1;
        end
        else if (hold_count > 0)
        begin
            hold_count--;
            out_stall <= (hold_count != 0);
        end
        else
        begin
            if ($urandom_range(0, 299) == 0)
                recv_calm = ~recv_calm;
            if (stall_left > 0)
                stall_left--;
            else if (!recv_calm)
                case ($urandom_range(0, 9))
                    0, 1: stall_left = $urandom_range(1, 4);
                    2: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : 0;
                    default: stall_left = 0;
                endcase
            out_stall <= (stall_left > 0);
        end
    end

    // ---------------------------------------------------------------
    // Rising edge: predict on each input transfer, check each output
    // transfer, track the register, and run the watchdog
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        traj_req_t it;
        traj_sample_t got;
        traj_sample_t want;
        if (!rst_n)
        begin
            took <= 1'b0;
            seg_cfg = 5'd1;
            errors = 0;
            evals_checked = 0;
            faults_seen = 0;
            idle_cycles = 0;
            for (int i = 0; i <= SEGS; i++)
                knot_mem[i] = '0;
            for (int i = 0; i < SEGS * AXES * TERMS; i++)
                coef_mem[i] = '0;
        end
        else
        begin
            took <= in_valid && !in_stall;
            if (cfg_we)
                seg_cfg = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                it = make_req(req_type, entry_index, axis_select, power_index,
                              write_value, sample_time);
                apply_request(it);
            end
            if (out_valid && !out_stall)
            begin
                got.pos = {pos_z, pos_y, pos_x};
                got.vel = {vel_z, vel_y, vel_x};
                got.acc = {acc_z, acc_y, acc_x};
                got.seg = segment_used;
                got.flt = fault;
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: sample with none expected: got %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    evals_checked++;
                    if (want.flt)
                        faults_seen++;
                    for (int a = 0; a < AXES; a++)
                    begin
                        if (got.pos[a] !== want.pos[a])
                        begin
                            $display("%0t: pos axis %0d expected %h got %h",
                                     $time, a, want.pos[a], got.pos[a]);
                            errors++;
                        end
                        if (got.vel[a] !== want.vel[a])
                        begin
                            $display("%0t: vel axis %0d expected %h got %h",
                                     $time, a, want.vel[a], got.vel[a]);
                            errors++;
                        end
                        if (got.acc[a] !== want.acc[a])
                        begin
                            $display("%0t: acc axis %0d expected %h got %h",
                                     $time, a, want.acc[a], got.acc[a]);
                            errors++;
                        end
                    end
                    if (got.seg !== want.seg)
                    begin
                        $display("%0t: segment_used expected %0d got %0d",
                                 $time, want.seg, got.seg);
                        errors++;
                    end
                    if (got.flt !== want.flt)
                    begin
                        $display("%0t: fault expected %0d got %0d", $time, want.flt, got.flt);
                        errors++;
                    end
                end
            end
            // watchdog: count cycles with no transfer on either channel
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
                $display("piecewise_septic_trajectory_eval_top test failed");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
rtl/pste_pkg.sv
rtl/pste_ram.sv
rtl/pste_div.sv
rtl/pste_ctrl.sv
rtl/pste_dp.sv
rtl/piecewise_septic_trajectory_eval_top.sv
tb/piecewise_septic_trajectory_eval_top_tb.sv
